### rtl/dark_channel_min_filter_defines.svh
// Assertion macros used by the RTL of the dark channel filter.
`ifndef DARK_CHANNEL_MIN_FILTER_DEFINES_SVH
`define DARK_CHANNEL_MIN_FILTER_DEFINES_SVH
`ifndef SYNTHESIS
`define DCM_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define DCM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define DCM_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define DCM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

### rtl/dcm_pkg.sv
`default_nettype none
package dcm_pkg;
    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_RADIUS_DEF = 7;
    localparam int MAX_HEIGHT     = 4096;
    localparam logic [7:0] PIX_MAX = 8'd255;

    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_RADIUS = 2'd2;

    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_DRAIN = 1'b1;

    function automatic logic [7:0] min8(input logic [7:0] a, input logic [7:0] b);
        return (a < b) ? a : b;
    endfunction
endpackage
`default_nettype wire

### rtl/dcm_if.sv
`default_nettype none
interface dcm_in_if;
    logic       valid;
    logic       ready;
    logic       cmd;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    modport source (output valid, cmd, blue, green, red, input ready);
    modport sink   (input valid, cmd, blue, green, red, output ready);
endinterface

interface dcm_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] dark_value;
    logic       frame_end;
    modport source (output valid, dark_value, frame_end, input ready);
    modport sink   (input valid, dark_value, frame_end, output ready);
endinterface

interface dcm_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [12:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

### rtl/dark_channel_min_filter.sv
// Dark channel minimum filter.
// Input channel: one item per pixel (cmd pixel) in raster order, or a drain
// item (cmd drain) that only asks for the next pending result. The per-pixel
// minimum of blue, green and red is written to a line store of
// 2*MAX_RADIUS+2 rows. Each item gives at most one result: the minimum over
// the clipped square window of the next pending output pixel, once that
// window has fully arrived.
// Timing: an item that gives no result leaves the block idle. An item that
// gives a result starts a sequencer that reads the window one cell a cycle
// from the single read port of the line store; the next item is taken only
// after the walk of the clipped window (rows*cols cells) and the states
// S_LAST and S_OUT. The read port sets the pace of the walk.
// The result waits in an output register; while it is not taken, no new
// item is accepted.
// Configuration: index 0 width, 1 height, 2 radius. The configuration channel
// is ready only while the block is idle. A write to one of them restarts the
// frame. Reset sets 640 x 480, radius 7, and all positions to zero; the line
// store needs no clearing since results only read cells of the same frame.
`default_nettype none
`include "dark_channel_min_filter_defines.svh"
module dark_channel_min_filter
    import dcm_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_RADIUS = MAX_RADIUS_DEF
) (
    input wire logic i_clk,
    input wire logic i_rst_n,
    dcm_in_if.sink   in_ch,
    dcm_out_if.source out_ch,
    dcm_cfg_if.sink  cfg_ch
);
    localparam int ROWS  = 2 * MAX_RADIUS + 2;
    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int RW    = $clog2(ROWS);
    localparam int DEPTH = ROWS * (2 ** CW);
    localparam int AW    = $clog2(DEPTH);
    localparam int RADW  = $clog2(MAX_RADIUS + 1);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SCAN = 4'b0010,
        S_LAST = 4'b0100,
        S_OUT  = 4'b1000
    } t_state;

    t_state r_state, n_state;

    logic [10:0] r_width;
    logic [12:0] r_height;
    logic [2:0]  r_radius;

    // Effective sizes: a zero width or height becomes one, large values saturate.
    logic [12:0] w_eff, h_eff;
    logic [RADW:0] rad_eff;
    always_comb begin
        if (r_width == 11'd0) w_eff = 13'd1;
        else if (32'(r_width) > MAX_WIDTH) w_eff = 13'(MAX_WIDTH);
        else w_eff = {2'b00, r_width};
        if (r_height == 13'd0) h_eff = 13'd1;
        else if (32'(r_height) > MAX_HEIGHT) h_eff = 13'(MAX_HEIGHT);
        else h_eff = r_height;
        if (32'(r_radius) > MAX_RADIUS) rad_eff = (RADW + 1)'(MAX_RADIUS);
        else rad_eff = (RADW + 1)'(r_radius);
    end

    logic [12:0] r_in_row, r_in_col, r_out_row, r_out_col;
    logic [RW-1:0] r_in_slot;
    logic [12:0] r_sc_row, r_sc_col, r_c0, r_c1, r_r1;
    logic [RW-1:0] r_sc_slot;
    logic [7:0]  r_min;
    logic [7:0]  r_dark;
    logic        r_last;

    logic in_acc, cfg_acc, out_acc;
    assign in_ch.ready  = (r_state == S_IDLE) && !cfg_ch.valid;
    assign cfg_ch.ready = (r_state == S_IDLE);
    assign in_acc  = in_ch.valid && in_ch.ready;
    assign cfg_acc = cfg_ch.valid && cfg_ch.ready;
    assign out_acc = out_ch.valid && out_ch.ready;
    assign out_ch.valid      = (r_state == S_OUT);
    assign out_ch.dark_value = r_dark;
    assign out_ch.frame_end  = r_last;

    // Pixel write and position after the write.
    logic       wr_en;
    logic [7:0] pix_min;
    logic [12:0] in_row_nx, in_col_nx;
    logic [RW-1:0] in_slot_nx;
    always_comb begin
        pix_min    = min8(min8(in_ch.blue, in_ch.green), in_ch.red);
        wr_en      = in_acc && (in_ch.cmd == CMD_PIXEL) && (r_in_row < h_eff);
        in_row_nx  = r_in_row;
        in_col_nx  = r_in_col;
        in_slot_nx = r_in_slot;
        if (wr_en) begin
            if (r_in_col + 13'd1 >= w_eff) begin
                in_col_nx = 13'd0;
                in_row_nx = r_in_row + 13'd1;
                in_slot_nx = (32'(r_in_slot) == ROWS - 1) ? '0 : r_in_slot + RW'(1);
            end else begin
                in_col_nx = r_in_col + 13'd1;
            end
        end
    end

    // Readiness of the next result against the updated input position.
    logic [12:0] tr, tc, r0, c0, rad13, lag;
    logic        ready_out;
    logic [RW-1:0] slot0;
    always_comb begin
        rad13 = 13'(rad_eff);
        tr = (r_out_row + rad13 > h_eff - 13'd1) ? h_eff - 13'd1 : r_out_row + rad13;
        tc = (r_out_col + rad13 > w_eff - 13'd1) ? w_eff - 13'd1 : r_out_col + rad13;
        r0 = (r_out_row > rad13) ? r_out_row - rad13 : 13'd0;
        c0 = (r_out_col > rad13) ? r_out_col - rad13 : 13'd0;
        if (r_out_row >= h_eff) ready_out = 1'b0;
        else if (in_row_nx >= h_eff) ready_out = 1'b1;
        else ready_out = (in_row_nx > tr) || (in_row_nx == tr && in_col_nx > tc);
        // Slot of row r0 relative to the input slot, which holds r_in_row.
        // Row r0 is never more than 2R+1 rows behind the input row.
        lag = r_in_row - r0;
        if (r_in_slot >= RW'(lag)) slot0 = r_in_slot - RW'(lag);
        else slot0 = RW'(32'(r_in_slot) + ROWS - 32'(lag));
    end

    logic [AW-1:0] raddr;
    logic [7:0]    rdata;
    assign raddr = AW'({r_sc_slot, r_sc_col[CW-1:0]});

    dcm_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_store (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (AW'({r_in_slot, r_in_col[CW-1:0]})),
        .i_wdata (pix_min),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // Result taken on this item, and whether it closes the frame.
    logic emit, emit_last, cfg_hit;
    assign emit      = (r_state == S_IDLE) && in_acc && ready_out;
    assign emit_last = (r_out_row == h_eff - 13'd1) && (r_out_col == w_eff - 13'd1);
    assign cfg_hit   = cfg_acc && (cfg_ch.index == REG_WIDTH || cfg_ch.index == REG_HEIGHT
                                   || cfg_ch.index == REG_RADIUS);

    // Scan sequencer: one cell address a cycle, its data in the cycle after.
    logic scan_end;
    assign scan_end = (r_sc_col == r_c1) && (r_sc_row == r_r1);
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (emit) n_state = S_SCAN;
            S_SCAN: if (scan_end) n_state = S_LAST;
            S_LAST: n_state = S_OUT;
            S_OUT:  if (out_acc) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    logic r_rd_vld;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_width   <= 11'd640;
            r_height  <= 13'd480;
            r_radius  <= 3'd7;
            r_in_row  <= '0;
            r_in_col  <= '0;
            r_in_slot <= '0;
            r_out_row <= '0;
            r_out_col <= '0;
            r_rd_vld  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= (r_state == S_SCAN);
            if (cfg_hit) begin
                case (cfg_ch.index)
                    REG_WIDTH:  r_width  <= cfg_ch.data[10:0];
                    REG_HEIGHT: r_height <= cfg_ch.data;
                    REG_RADIUS: r_radius <= cfg_ch.data[2:0];
                    default:    r_radius <= r_radius;
                endcase
                r_in_row  <= '0;
                r_in_col  <= '0;
                r_in_slot <= '0;
                r_out_row <= '0;
                r_out_col <= '0;
            end else if (emit && emit_last) begin
                // The frame is complete: every position returns to zero.
                r_last    <= 1'b1;
                r_in_row  <= '0;
                r_in_col  <= '0;
                r_in_slot <= '0;
                r_out_row <= '0;
                r_out_col <= '0;
            end else begin
                r_in_row  <= in_row_nx;
                r_in_col  <= in_col_nx;
                r_in_slot <= in_slot_nx;
                if (emit) begin
                    r_last <= 1'b0;
                    if (r_out_col + 13'd1 >= w_eff) begin
                        r_out_col <= '0;
                        r_out_row <= r_out_row + 13'd1;
                    end else begin
                        r_out_col <= r_out_col + 13'd1;
                    end
                end
            end
        end
    end

    // Scan registers and running minimum.
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE) begin
            r_sc_row  <= r0;
            r_sc_col  <= c0;
            r_c0      <= c0;
            r_c1      <= tc;
            r_r1      <= tr;
            r_sc_slot <= slot0;
            r_min     <= PIX_MAX;
        end else if (r_state == S_SCAN && !scan_end) begin
            if (r_sc_col == r_c1) begin
                r_sc_col  <= r_c0;
                r_sc_row  <= r_sc_row + 13'd1;
                r_sc_slot <= (32'(r_sc_slot) == ROWS - 1) ? '0 : r_sc_slot + RW'(1);
            end else begin
                r_sc_col <= r_sc_col + 13'd1;
            end
        end
        if (r_rd_vld) begin
            r_min <= min8(r_min, rdata);
        end
        if (r_state == S_LAST) begin
            r_dark <= min8(r_min, rdata);
        end
    end

    `DCM_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_ch.valid && !out_ch.ready && !cfg_acc,
        out_ch.valid && $stable(out_ch.dark_value), "result changed while stalled")
    `DCM_ASSERT_IMPL(a_no_in_busy, i_clk, i_rst_n, r_state != S_IDLE, !in_ch.ready,
        "item taken while busy")
    `DCM_ASSERT_IMPL(a_out_order, i_clk, i_rst_n, r_out_row < h_eff, r_out_row <= r_in_row,
        "output ahead of input")
endmodule
`default_nettype wire

### rtl/dcm_ram.sv
`default_nettype none
module dcm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

### test/tb_dark_channel_min_filter.sv
`timescale 1ns / 1ps
`default_nettype none
module tb_dark_channel_min_filter;
    import dcm_pkg::*;

    // Register index that the block does not decode.
    localparam logic [1:0] REG_UNUSED = 2'd3;
    localparam int STORE_ROWS  = 2 * MAX_RADIUS_DEF + 2;
    // Longest window walk of one item, with some margin.
    localparam int SETTLE_CYCLES = (2 * MAX_RADIUS_DEF + 1) ** 2 + 20;
    localparam int RANDOM_ITEMS  = 1650;

    typedef struct packed {
        logic [7:0] dark;
        logic       last;
    } t_dark_result;

    typedef struct {
        bit          do_cfg;
        bit          bad_index;
        logic [10:0] width;
        logic [12:0] height;
        logic [2:0]  radius;
        logic        cmd;
        logic [7:0]  blue;
        logic [7:0]  green;
        logic [7:0]  red;
        bit          typed;
        bit          has_result;
        logic [7:0]  dark;
        logic        last;
    } t_stim_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    dcm_in_if  pix_bus ();
    dcm_out_if dark_bus ();
    dcm_cfg_if cfg_bus ();

    dark_channel_min_filter dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .in_ch  (pix_bus),
        .out_ch (dark_bus),
        .cfg_ch (cfg_bus)
    );

    always #5 i_clk = ~i_clk;

    // Predictor state: registers, line store and stream positions.
    logic [10:0] cfg_width;
    logic [12:0] cfg_height;
    logic [2:0]  cfg_radius;
    logic [7:0]  minima_store [STORE_ROWS * MAX_WIDTH_DEF];
    int in_row, in_col, out_row, out_col;
    bit frame_done;

    t_dark_result dark_expected [$];
    int  mismatches = 0;
    bit  calm = 1'b0;
    int  useful_items = 0;

    // Append one expected result at the tail of the queue.
    function automatic void queue_result(t_dark_result res);
        dark_expected.insert(dark_expected.size(), res);
    endfunction

    function automatic int frame_w();
        if (cfg_width == 0) return 1;
        return (cfg_width > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : int'(cfg_width);
    endfunction

    function automatic int frame_h();
        if (cfg_height == 0) return 1;
        return (cfg_height > MAX_HEIGHT) ? MAX_HEIGHT : int'(cfg_height);
    endfunction

    function automatic void restart_positions();
        in_row = 0;
        in_col = 0;
        out_row = 0;
        out_col = 0;
    endfunction

    function automatic void apply_register(logic [1:0] idx, logic [12:0] data);
        case (idx)
            REG_WIDTH:  cfg_width  = data[10:0];
            REG_HEIGHT: cfg_height = data;
            REG_RADIUS: cfg_radius = data[2:0];
            default:    return;
        endcase
        restart_positions();
    endfunction

    // Stores the pixel minimum, then forms the next result if its window is in.
    // Returns 1 when the item stored a pixel or produced a result.
    function automatic bit predict_dark(logic cmd, logic [7:0] b, logic [7:0] g,
                                        logic [7:0] r, output bit got,
                                        output t_dark_result res);
        int w, h, rad, tr, tc, r0, r1, c0, c1;
        logic [7:0] m;
        bit ready, stored;
        w = frame_w();
        h = frame_h();
        rad = cfg_radius;
        got = 1'b0;
        res = '0;
        stored = 1'b0;
        if (cmd == CMD_PIXEL && in_row < h) begin
            m = (b < g) ? b : g;
            if (r < m) m = r;
            minima_store[(in_row % STORE_ROWS) * MAX_WIDTH_DEF + in_col] = m;
            stored = 1'b1;
            in_col++;
            if (in_col >= w) begin
                in_col = 0;
                in_row++;
            end
        end
        if (out_row >= h) begin
            ready = 1'b0;
        end else if (in_row >= h) begin
            ready = 1'b1;
        end else begin
            tr = (out_row + rad > h - 1) ? h - 1 : out_row + rad;
            tc = (out_col + rad > w - 1) ? w - 1 : out_col + rad;
            ready = (in_row > tr) || (in_row == tr && in_col > tc);
        end
        if (!ready) return stored;
        r0 = (out_row > rad) ? out_row - rad : 0;
        r1 = (out_row + rad > h - 1) ? h - 1 : out_row + rad;
        c0 = (out_col > rad) ? out_col - rad : 0;
        c1 = (out_col + rad > w - 1) ? w - 1 : out_col + rad;
        m = PIX_MAX;
        for (int x = r0; x <= r1; x++) begin
            for (int y = c0; y <= c1; y++) begin
                if (minima_store[(x % STORE_ROWS) * MAX_WIDTH_DEF + y] < m)
                    m = minima_store[(x % STORE_ROWS) * MAX_WIDTH_DEF + y];
            end
        end
        res.dark = m;
        res.last = (out_row == h - 1) && (out_col == w - 1);
        got = 1'b1;
        if (res.last) begin
            restart_positions();
            frame_done = 1'b1;
        end else begin
            out_col++;
            if (out_col >= w) begin
                out_col = 0;
                out_row++;
            end
        end
        return 1'b1;
    endfunction

    // Write one register through the configuration channel.
    task automatic write_register(logic [1:0] idx, logic [12:0] data);
        @(negedge i_clk);
        cfg_bus.valid = 1'b1;
        cfg_bus.index = idx;
        cfg_bus.data  = data;
        @(posedge i_clk);
        while (!cfg_bus.ready) @(posedge i_clk);
        apply_register(idx, data);
        @(negedge i_clk);
        cfg_bus.valid = 1'b0;
    endtask

    // Stop sending, then wait until every expected result is out and the
    // block has settled.
    task automatic wait_idle();
        @(negedge i_clk);
        pix_bus.valid = 1'b0;
        while (dark_expected.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_frame(logic [10:0] w, logic [12:0] h, logic [2:0] rad);
        wait_idle();
        write_register(REG_WIDTH, {2'b00, w});
        write_register(REG_HEIGHT, h);
        write_register(REG_RADIUS, {10'd0, rad});
    endtask

    // Random gap on the sending side, with valid held low.
    task automatic sender_gap();
        int n;
        n = $urandom_range(1, 5);
        @(negedge i_clk);
        pix_bus.valid = 1'b0;
        repeat (n - 1) @(negedge i_clk);
    endtask

    // Send one item; the predictor runs when it is accepted.
    task automatic send_item(logic cmd, logic [7:0] b, logic [7:0] g, logic [7:0] r,
                             output bit useful, output bit got,
                             output t_dark_result res);
        if (!calm && $urandom_range(0, 9) == 0) sender_gap();
        @(negedge i_clk);
        pix_bus.valid = 1'b1;
        pix_bus.cmd   = cmd;
        pix_bus.blue  = b;
        pix_bus.green = g;
        pix_bus.red   = r;
        @(posedge i_clk);
        while (!pix_bus.ready) @(posedge i_clk);
        useful = predict_dark(cmd, b, g, r, got, res);
    endtask

    task automatic send_random(logic cmd);
        bit useful, got;
        t_dark_result res;
        send_item(cmd, 8'($urandom), 8'($urandom), 8'($urandom), useful, got, res);
        if (got) queue_result(res);
        if (useful) useful_items++;
    endtask

    // Receiver: random stall bursts, none in the closing stretch.
    int stall_left = 0;
    always @(negedge i_clk) begin
        if (calm) begin
            dark_bus.ready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            dark_bus.ready <= 1'b0;
        end else if ($urandom_range(0, 7) == 0) begin
            stall_left <= $urandom_range(0, 4);
            dark_bus.ready <= 1'b0;
        end else begin
            dark_bus.ready <= 1'b1;
        end
    end

    // Compare each accepted result with the oldest expectation.
    always @(posedge i_clk) begin
        t_dark_result want;
        if (i_rst_n && dark_bus.valid && dark_bus.ready) begin
            if (dark_expected.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result: dark %0d end %0b",
                             dark_bus.dark_value, dark_bus.frame_end);
            end else begin
                want = dark_expected.pop_front();
                if (dark_bus.dark_value !== want.dark || dark_bus.frame_end !== want.last)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Mismatch: expected dark %0d end %0b, got dark %0d end %0b",
                                 want.dark, want.last, dark_bus.dark_value,
                                 dark_bus.frame_end);
                end
            end
        end
    end

    // Directed rows: the first runs on the reset frame; the ones after it run on
    // a single-pixel frame where each result is simply the pixel minimum.
    t_stim_row directed [] = '{
        '{0, 0, 0, 0, 0, CMD_PIXEL, 8'd1, 8'd2, 8'd3, 1, 0, 8'd0, 1'b0},
        '{1, 0, 11'd1, 13'd1, 3'd0, CMD_PIXEL, 8'd10, 8'd20, 8'd5, 1, 1, 8'd5, 1'b1},
        '{0, 0, 0, 0, 0, CMD_PIXEL, 8'd0, 8'd0, 8'd0, 1, 1, 8'd0, 1'b1},
        '{0, 0, 0, 0, 0, CMD_PIXEL, 8'd255, 8'd255, 8'd255, 1, 1, 8'd255, 1'b1},
        '{0, 0, 0, 0, 0, CMD_PIXEL, 8'd255, 8'd7, 8'd255, 1, 1, 8'd7, 1'b1},
        '{0, 0, 0, 0, 0, CMD_PIXEL, 8'd200, 8'd255, 8'd3, 1, 1, 8'd3, 1'b1},
        '{0, 0, 0, 0, 0, CMD_PIXEL, 8'd1, 8'd255, 8'd255, 1, 1, 8'd1, 1'b1},
        '{0, 0, 0, 0, 0, CMD_DRAIN, 8'd9, 8'd9, 8'd9, 1, 0, 8'd0, 1'b0},
        '{1, 0, 11'd0, 13'd0, 3'd0, CMD_PIXEL, 8'd9, 8'd8, 8'd9, 1, 1, 8'd8, 1'b1},
        // Two by two frame, radius one: nothing comes out until the frame is in,
        // then late pixels are discarded and act as drains.
        '{1, 0, 11'd2, 13'd2, 3'd1, CMD_PIXEL, 8'd40, 8'd50, 8'd60, 0, 0, 8'd0, 1'b0},
        '{0, 0, 0, 0, 0, CMD_DRAIN, 8'd0, 8'd0, 8'd0, 0, 0, 8'd0, 1'b0},
        '{0, 0, 0, 0, 0, CMD_PIXEL, 8'd30, 8'd90, 8'd90, 0, 0, 8'd0, 1'b0},
        '{0, 0, 0, 0, 0, CMD_PIXEL, 8'd70, 8'd70, 8'd70, 0, 0, 8'd0, 1'b0},
        '{0, 0, 0, 0, 0, CMD_PIXEL, 8'd99, 8'd20, 8'd99, 0, 0, 8'd0, 1'b0},
        '{0, 0, 0, 0, 0, CMD_PIXEL, 8'd0, 8'd0, 8'd0, 0, 0, 8'd0, 1'b0},
        '{0, 0, 0, 0, 0, CMD_DRAIN, 8'd0, 8'd0, 8'd0, 0, 0, 8'd0, 1'b0},
        '{0, 0, 0, 0, 0, CMD_DRAIN, 8'd0, 8'd0, 8'd0, 0, 0, 8'd0, 1'b0},
        '{0, 0, 0, 0, 0, CMD_DRAIN, 8'd0, 8'd0, 8'd0, 0, 0, 8'd0, 1'b0},
        // A write to an undecoded index must leave the frame alone.
        '{1, 1, 11'd3, 13'd1, 3'd7, CMD_PIXEL, 8'd5, 8'd6, 8'd7, 0, 0, 8'd0, 1'b0},
        '{0, 0, 0, 0, 0, CMD_PIXEL, 8'd8, 8'd2, 8'd9, 0, 0, 8'd0, 1'b0},
        '{0, 0, 0, 0, 0, CMD_PIXEL, 8'd128, 8'd127, 8'd129, 0, 0, 8'd0, 1'b0}
    };

    initial begin
        bit useful, got;
        t_dark_result res;
        int phase, w, h, rad, total, stop_at, frames;
        t_dark_result want;

        pix_bus.valid = 1'b0;
        pix_bus.cmd   = CMD_PIXEL;
        pix_bus.blue  = '0;
        pix_bus.green = '0;
        pix_bus.red   = '0;
        cfg_bus.valid = 1'b0;
        cfg_bus.index = REG_WIDTH;
        cfg_bus.data  = '0;
        cfg_width  = 11'd640;
        cfg_height = 13'd480;
        cfg_radius = 3'd7;
        restart_positions();

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part.
        foreach (directed[i]) begin
            if (directed[i].do_cfg) begin
                if (directed[i].bad_index) begin
                    wait_idle();
                    write_register(REG_UNUSED, 13'h1FFF);
                end else begin
                    set_frame(directed[i].width, directed[i].height, directed[i].radius);
                end
            end
            send_item(directed[i].cmd, directed[i].blue, directed[i].green,
                      directed[i].red, useful, got, res);
            if (directed[i].typed) begin
                if (directed[i].has_result) begin
                    want.dark = directed[i].dark;
                    want.last = directed[i].last;
                    queue_result(want);
                end
            end else if (got) begin
                queue_result(res);
            end
        end

        // Random part: whole frames with random content, plus stray drains,
        // late pixels and the odd aborted frame.
        phase = 0;
        while (useful_items < RANDOM_ITEMS) begin
            case (phase)
                1: begin w = 2047; h = 1;  rad = 7; end
                3: begin w = 1;    h = 20; rad = 7; end
                5: begin w = 20;   h = 0;  rad = 3; end
                default: begin
                    w = $urandom_range(0, 12);
                    h = $urandom_range(0, 8);
                    rad = $urandom_range(0, 7);
                end
            endcase
            calm = (useful_items > RANDOM_ITEMS - 250);
            set_frame(11'(w), 13'(h), 3'(rad));
            frames = (phase == 1) ? 1 : $urandom_range(1, 2);
            for (int f = 0; f < frames; f++) begin
                total = frame_w() * frame_h();
                stop_at = ($urandom_range(0, 9) == 0) ? $urandom_range(0, total) : total;
                frame_done = 1'b0;
                for (int p = 0; p < stop_at; p++) begin
                    if ($urandom_range(0, 7) == 0) send_random(CMD_DRAIN);
                    // Hold off once in mid frame until everything is out.
                    if (phase == 2 && p == stop_at / 2) begin
                        @(negedge i_clk);
                        pix_bus.valid = 1'b0;
                        while (dark_expected.size() != 0) @(posedge i_clk);
                    end
                    send_random(CMD_PIXEL);
                end
                if (stop_at != total) break;
                while (!frame_done)
                    send_random(($urandom_range(0, 3) == 0) ? CMD_PIXEL : CMD_DRAIN);
            end
            phase++;
        end

        @(negedge i_clk);
        pix_bus.valid = 1'b0;
        wait_idle();
        if (mismatches == 0 && dark_expected.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #100ms;
        $display("RESULT: ERROR");
        $finish;
    end
endmodule
`default_nettype wire

### dark_channel_min_filter.f
+incdir+rtl
rtl/dcm_pkg.sv
rtl/dcm_if.sv
rtl/dcm_ram.sv
rtl/dark_channel_min_filter.sv
test/tb_dark_channel_min_filter.sv
